### src/gi2d_pkg.sv
// shared types, constants and helpers for the 2d gravity interaction pipeline
`timescale 1ns / 1ps
`default_nettype none

package gi2d_pkg;

  // pipeline geometry
  localparam int SqrtSteps = 32;
  localparam int DivSteps  = 34;
  localparam int Stages    = 3 + SqrtSteps + 4 + DivSteps + 1;

  // configuration register indexes
  localparam logic [1:0] REG_GRAV  = 2'd0;
  localparam logic [1:0] REG_SOFT  = 2'd1;
  localparam logic [1:0] REG_ANGLE = 2'd2;

  localparam logic [15:0] ANGLE_RESET = 16'd3686;

  // per-item side information carried through the front stages
  typedef struct packed {
    logic        is_cell;
    logic        kill;
    logic        neg_x;
    logic        neg_y;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] mass;
    logic [30:0] size;
  } item_t;

  // flags carried through the divider stages
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic zero;
    logic open;
  } flags_t;

  // clamp a quotient magnitude and apply the sign of the offset
  function automatic logic [31:0] sat_comp(input logic [33:0] q, input logic neg);
    logic [33:0] qs;
    logic [33:0] nq;
    begin
      if (neg) begin
        qs = (q > 34'h0_8000_0000) ? 34'h0_8000_0000 : q;
        nq = 34'd0 - qs;
        sat_comp = nq[31:0];
      end else begin
        qs = (q > 34'h0_7FFF_FFFF) ? 34'h0_7FFF_FFFF : q;
        sat_comp = qs[31:0];
      end
    end
  endfunction

endpackage

`default_nettype wire

### src/gravity_interaction_2d_top.sv
// top level of the 2d gravity interaction pipeline
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-------------------------------------------
//  config   | psel penable pwrite pready   | paddr pwdata prdata
//  input    | in_valid in_ready            | req_type target_x/y partner_x/y mass size self
//  output   | out_valid out_ready          | accel_x accel_y open_cell
//
// one transfer enters per cycle while the pipeline advances; items pass front stages,
// 32 square root steps, 34 divider steps for both components, multiply and output stages
// the whole pipeline advances together whenever the output register is empty or taken
// reset (synchronous) clears valid bits and resets configuration only
// a stall freezes every stage, so no item is lost or repeated
`timescale 1ns / 1ps
`default_nettype none

module gravity_interaction_2d_top import gi2d_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        req_type,
  input  wire logic [31:0] target_x,
  input  wire logic [31:0] target_y,
  input  wire logic [31:0] partner_x,
  input  wire logic [31:0] partner_y,
  input  wire logic [31:0] partner_mass,
  input  wire logic [30:0] cell_size,
  input  wire logic        is_self,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      accel_x,
  output logic [31:0]      accel_y,
  output logic             open_cell
);

  logic [31:0] grav_const;
  logic [31:0] soften_sq;
  logic [15:0] open_angle;
  logic        adv;
  logic [Stages-1:0] vld;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grav_const <= '0;
      soften_sq  <= '0;
      open_angle <= ANGLE_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_GRAV:  grav_const <= pwdata;
        REG_SOFT:  soften_sq  <= pwdata;
        REG_ANGLE: open_angle <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_GRAV:  prdata = grav_const;
      REG_SOFT:  prdata = soften_sq;
      REG_ANGLE: prdata = {16'd0, open_angle};
      default:   prdata = '0;
    endcase
  end

  // global advance and valid chain
  assign adv       = !vld[Stages-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[Stages-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Stages-2:0], in_valid};
    end
  end

  // stage 0: offsets and magnitudes
  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic [32:0]        adx;
  logic [32:0]        ady;
  item_t              s0_it;

  assign dx  = $signed({partner_x[31], partner_x}) - $signed({target_x[31], target_x});
  assign dy  = $signed({partner_y[31], partner_y}) - $signed({target_y[31], target_y});
  assign adx = dx[32] ? 33'd0 - dx : dx;
  assign ady = dy[32] ? 33'd0 - dy : dy;

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_it.is_cell <= req_type;
      s0_it.kill    <= !req_type && is_self;
      s0_it.neg_x   <= dx[32];
      s0_it.neg_y   <= dy[32];
      s0_it.ax      <= adx[31:0];
      s0_it.ay      <= ady[31:0];
      s0_it.mass    <= partner_mass;
      s0_it.size    <= cell_size;
    end
  end

  // stage 1: squares
  logic [63:0] pxx;
  logic [63:0] pyy;
  item_t       s1_it;

  always_ff @(posedge clk) begin
    if (adv) begin
      pxx   <= s0_it.ax * s0_it.ax;
      pyy   <= s0_it.ay * s0_it.ay;
      s1_it <= s0_it;
    end
  end

  // stage 2: squared distance with softening for bodies
  logic [63:0] sq_v   [0:SqrtSteps];
  logic [63:0] sq_res [0:SqrtSteps];
  logic [63:0] sq_r2  [0:SqrtSteps];
  item_t       sq_it  [0:SqrtSteps];
  logic [63:0] r2_sum;

  assign r2_sum = {2'd0, pxx[63:2]} + {2'd0, pyy[63:2]}
                + (s1_it.is_cell ? 64'd0 : {18'd0, soften_sq, 14'd0});

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_v[0]   <= r2_sum;
      sq_res[0] <= '0;
      sq_r2[0]  <= r2_sum;
      sq_it[0]  <= s1_it;
    end
  end

  // square root, one result bit per stage
  for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * i);
    logic [64:0] sum;
    logic        ge;

    assign sum = {1'b0, sq_res[i]} + {1'b0, Bit};
    assign ge  = {1'b0, sq_v[i]} >= sum;

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_v[i+1]   <= ge ? sq_v[i] - sum[63:0] : sq_v[i];
        sq_res[i+1] <= ge ? (sq_res[i] >> 1) + Bit : sq_res[i] >> 1;
        sq_r2[i+1]  <= sq_r2[i];
        sq_it[i+1]  <= sq_it[i];
      end
    end
  end

  // m1: partial products of r^3, gm and the acceptance product
  logic [31:0] r;
  logic [63:0] m1_r3lo;
  logic [63:0] m1_r3hi;
  logic [63:0] m1_gm;
  logic [47:0] m1_ar;
  logic        m1_rz;
  item_t       m1_it;

  assign r = sq_res[SqrtSteps][31:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r3lo <= sq_r2[SqrtSteps][31:0] * r;
      m1_r3hi <= sq_r2[SqrtSteps][63:32] * r;
      m1_gm   <= grav_const * sq_it[SqrtSteps].mass;
      m1_ar   <= open_angle * r;
      m1_rz   <= (r == 32'd0);
      m1_it   <= sq_it[SqrtSteps];
    end
  end

  // m2: r^3 and the cell decision
  logic [95:0] m2_r3;
  logic [63:0] m2_gm;
  logic        m2_open;
  logic        m2_zero;
  item_t       m2_it;
  logic        open_c;

  assign open_c = m1_it.is_cell && (m1_rz || ({6'd0, m1_it.size, 11'd0} > m1_ar));

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_r3   <= {32'd0, m1_r3lo} + {m1_r3hi, 32'd0};
      m2_gm   <= m1_gm;
      m2_open <= open_c;
      m2_zero <= m1_it.kill || m1_rz || open_c;
      m2_it   <= m1_it;
    end
  end

  // m3: partial products of gm times each offset
  logic [63:0] m3_pxl;
  logic [63:0] m3_pxh;
  logic [63:0] m3_pyl;
  logic [63:0] m3_pyh;
  logic [95:0] m3_r3;
  flags_t      m3_fl;

  always_ff @(posedge clk) begin
    if (adv) begin
      m3_pxl      <= m2_gm[31:0] * m2_it.ax;
      m3_pxh      <= m2_gm[63:32] * m2_it.ax;
      m3_pyl      <= m2_gm[31:0] * m2_it.ay;
      m3_pyh      <= m2_gm[63:32] * m2_it.ay;
      m3_r3       <= m2_r3;
      m3_fl.neg_x <= m2_it.neg_x;
      m3_fl.neg_y <= m2_it.neg_y;
      m3_fl.zero  <= m2_zero;
      m3_fl.open  <= m2_open;
    end
  end

  // m4: numerators, then the shared-shape dividers
  logic [100:0] dv_rx [0:DivSteps];
  logic [100:0] dv_ry [0:DivSteps];
  logic [33:0]  dv_qx [0:DivSteps];
  logic [33:0]  dv_qy [0:DivSteps];
  logic [95:0]  dv_r3 [0:DivSteps];
  flags_t       dv_fl [0:DivSteps];
  logic [95:0]  numx;
  logic [95:0]  numy;

  assign numx = {32'd0, m3_pxl} + {m3_pxh, 32'd0};
  assign numy = {32'd0, m3_pyl} + {m3_pyh, 32'd0};

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rx[0] <= {numx, 5'd0};
      dv_ry[0] <= {numy, 5'd0};
      dv_qx[0] <= '0;
      dv_qy[0] <= '0;
      dv_r3[0] <= m3_r3;
      dv_fl[0] <= m3_fl;
    end
  end

  // restoring division, one quotient bit per stage, msb first
  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    localparam int Sh = DivSteps - 1 - j;
    logic [129:0] t;
    logic         gex;
    logic         gey;

    assign t   = {34'd0, dv_r3[j]} << Sh;
    assign gex = {29'd0, dv_rx[j]} >= t;
    assign gey = {29'd0, dv_ry[j]} >= t;

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rx[j+1] <= gex ? dv_rx[j] - t[100:0] : dv_rx[j];
        dv_ry[j+1] <= gey ? dv_ry[j] - t[100:0] : dv_ry[j];
        dv_qx[j+1] <= dv_qx[j] | ({33'd0, gex} << Sh);
        dv_qy[j+1] <= dv_qy[j] | ({33'd0, gey} << Sh);
        dv_r3[j+1] <= dv_r3[j];
        dv_fl[j+1] <= dv_fl[j];
      end
    end
  end

  // output register: saturation, sign and zeroing
  always_ff @(posedge clk) begin
    if (adv) begin
      accel_x   <= dv_fl[DivSteps].zero ? 32'd0
                 : sat_comp(dv_qx[DivSteps], dv_fl[DivSteps].neg_x);
      accel_y   <= dv_fl[DivSteps].zero ? 32'd0
                 : sat_comp(dv_qy[DivSteps], dv_fl[DivSteps].neg_y);
      open_cell <= dv_fl[DivSteps].open;
    end
  end

endmodule

`default_nettype wire
